>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the noise hash core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked out of reset.
`define SVNH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define SVNH_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/svnh_pkg.sv
// ----------------------------------------------------------------------------
// svnh_pkg
// Types, constants and the control store of the smoothed value noise core.
// ----------------------------------------------------------------------------
package svnh_pkg;

	// Ring limit and the width of a ring number.
	localparam int unsigned MAX_RINGS = 7;
	localparam int unsigned RING_W    = $clog2(MAX_RINGS + 1);

	// Datapath widths.
	localparam int unsigned COORD_W = 32;
	localparam int unsigned PRIME_W = 31;
	localparam int unsigned OUT_W   = 48;
	localparam int unsigned SH_W    = 4;
	localparam int unsigned PC_W    = 4;
	localparam int unsigned IDX_W   = 2;

	// Q2.30 one, and the output scale shift for the center point.
	localparam logic [COORD_W-1:0] VAL_ONE   = 32'h4000_0000;
	localparam logic [SH_W-1:0]    SH_CENTER = 4'd14;
	localparam logic [SH_W-1:0]    SH_SIDE0  = 4'd15;

	// Reset values of the configuration registers.
	localparam logic [RING_W-1:0]  RING_RESET = 3'd1;
	localparam logic [PRIME_W-1:0] PA_RESET   = 31'd15731;
	localparam logic [PRIME_W-1:0] PB_RESET   = 31'd789221;
	localparam logic [PRIME_W-1:0] PC_RESET   = 31'd1376312589;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_RING_COUNT = 2'd0;
	localparam logic [IDX_W-1:0] REG_PRIME_A    = 2'd1;
	localparam logic [IDX_W-1:0] REG_PRIME_B    = 2'd2;
	localparam logic [IDX_W-1:0] REG_PRIME_C    = 2'd3;

	// Program addresses.
	localparam logic [PC_W-1:0] PC_IDLE       = 4'd0;
	localparam logic [PC_W-1:0] PC_CENTER     = 4'd1;
	localparam logic [PC_W-1:0] PC_RING_FIRST = 4'd2;
	localparam logic [PC_W-1:0] PC_RING_2     = 4'd3;
	localparam logic [PC_W-1:0] PC_RING_3     = 4'd4;
	localparam logic [PC_W-1:0] PC_RING_4     = 4'd5;
	localparam logic [PC_W-1:0] PC_RING_5     = 4'd6;
	localparam logic [PC_W-1:0] PC_RING_6     = 4'd7;
	localparam logic [PC_W-1:0] PC_RING_7     = 4'd8;
	localparam logic [PC_W-1:0] PC_RING_LAST  = 4'd9;
	localparam logic [PC_W-1:0] PC_DRAIN      = 4'd10;

	// Coordinate offset applied to one axis.
	typedef enum logic [1:0] {
		OFF_ZERO,
		OFF_PLUS,
		OFF_MINUS
	} off_sel_t;

	// Weight class of a sampled point.
	typedef enum logic [1:0] {
		WCLS_CENTER,
		WCLS_SIDE,
		WCLS_DIAG
	} wcls_t;

	// Jump conditions of the sequencer.
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_START,
		COND_NO_RINGS,
		COND_RING_MORE,
		COND_DONE
	} cond_t;

	// One control word.
	typedef struct packed {
		logic            issue;
		off_sel_t        dx;
		off_sel_t        dy;
		wcls_t           wcls;
		cond_t           cond;
		logic            hold;
		logic [PC_W-1:0] target;
	} ucode_t;

	// Point request into the hash pipeline.
	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [SH_W-1:0]    shift;
	} point_req_t;

	// Hashed point value out of the pipeline.
	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] value;
		logic [SH_W-1:0]    shift;
		logic               busy;
	} point_res_t;

	// Word builder keeps the control store readable.
	function automatic ucode_t uw(logic iss, off_sel_t dx, off_sel_t dy, wcls_t wc,
			cond_t cnd, logic hld, logic [PC_W-1:0] tgt);
		ucode_t w;
		w.issue  = iss;
		w.dx     = dx;
		w.dy     = dy;
		w.wcls   = wc;
		w.cond   = cnd;
		w.hold   = hld;
		w.target = tgt;
		return w;
	endfunction

	// Control store: idle, center, eight ring points with a loop, drain.
	function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			PC_IDLE:       w = uw(1'b0, OFF_ZERO, OFF_ZERO, WCLS_CENTER,
					COND_START, 1'b1, PC_CENTER);
			PC_CENTER:     w = uw(1'b1, OFF_ZERO, OFF_ZERO, WCLS_CENTER,
					COND_NO_RINGS, 1'b0, PC_DRAIN);
			PC_RING_FIRST: w = uw(1'b1, OFF_PLUS, OFF_ZERO, WCLS_SIDE,
					COND_NEVER, 1'b0, PC_IDLE);
			PC_RING_2:     w = uw(1'b1, OFF_MINUS, OFF_ZERO, WCLS_SIDE,
					COND_NEVER, 1'b0, PC_IDLE);
			PC_RING_3:     w = uw(1'b1, OFF_ZERO, OFF_PLUS, WCLS_SIDE,
					COND_NEVER, 1'b0, PC_IDLE);
			PC_RING_4:     w = uw(1'b1, OFF_ZERO, OFF_MINUS, WCLS_SIDE,
					COND_NEVER, 1'b0, PC_IDLE);
			PC_RING_5:     w = uw(1'b1, OFF_MINUS, OFF_MINUS, WCLS_DIAG,
					COND_NEVER, 1'b0, PC_IDLE);
			PC_RING_6:     w = uw(1'b1, OFF_PLUS, OFF_MINUS, WCLS_DIAG,
					COND_NEVER, 1'b0, PC_IDLE);
			PC_RING_7:     w = uw(1'b1, OFF_MINUS, OFF_PLUS, WCLS_DIAG,
					COND_NEVER, 1'b0, PC_IDLE);
			PC_RING_LAST:  w = uw(1'b1, OFF_PLUS, OFF_PLUS, WCLS_DIAG,
					COND_RING_MORE, 1'b0, PC_RING_FIRST);
			PC_DRAIN:      w = uw(1'b0, OFF_ZERO, OFF_ZERO, WCLS_CENTER,
					COND_DONE, 1'b1, PC_IDLE);
			default:       w = uw(1'b0, OFF_ZERO, OFF_ZERO, WCLS_CENTER,
					COND_NEVER, 1'b0, PC_IDLE);
		endcase
		return w;
	endfunction

endpackage

>>> rtl/core/smoothed_value_noise_hash_core.sv
// The input is stalled while a walk is under way, so one coordinate pair is worked at a time.
// The walk is paced by the shared hash pipeline, which takes one lattice point per cycle,
// plus its five-stage drain before the sum is final.
// Reset: arst_n clears the sequencer and valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// smoothed_value_noise_hash_core
// Microcoded sequencer that walks the center and rings through a shared hash
// pipeline and accumulates the weighted point values exactly.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smoothed_value_noise_hash_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [svnh_pkg::COORD_W-1:0]  coord_x,
	input  logic signed [svnh_pkg::COORD_W-1:0]  coord_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [svnh_pkg::OUT_W-1:0]    noise_value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [svnh_pkg::IDX_W-1:0]           cfg_index,
	input  logic [svnh_pkg::PRIME_W-1:0]         cfg_data
);

	logic [svnh_pkg::RING_W-1:0]   ring_count_q, ring_q;
	logic [svnh_pkg::PRIME_W-1:0]  prime_a_q, prime_b_q, prime_c_q;
	logic [svnh_pkg::COORD_W-1:0]  x_q, y_q, ring_ext;
	logic [svnh_pkg::PC_W-1:0]     pc_q, pc_nxt;
	logic [svnh_pkg::OUT_W-1:0]    acc_q, out_q, contrib;
	logic                          out_valid_q;
	logic                          in_xfer, cfg_xfer, jump, do_start, do_ring, do_done;
	svnh_pkg::ucode_t              uc;
	svnh_pkg::point_req_t          req;
	svnh_pkg::point_res_t          res;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;
	assign in_stall  = (pc_q != svnh_pkg::PC_IDLE);
	assign in_xfer   = in_valid & ~in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q <= svnh_pkg::RING_RESET;
			prime_a_q    <= svnh_pkg::PA_RESET;
			prime_b_q    <= svnh_pkg::PB_RESET;
			prime_c_q    <= svnh_pkg::PC_RESET;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				svnh_pkg::REG_RING_COUNT: ring_count_q <= cfg_data[svnh_pkg::RING_W-1:0];
				svnh_pkg::REG_PRIME_A:    prime_a_q    <= cfg_data;
				svnh_pkg::REG_PRIME_B:    prime_b_q    <= cfg_data;
				svnh_pkg::REG_PRIME_C:    prime_c_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Fetch the control word and resolve its jump condition.
	always_comb begin
		uc   = svnh_pkg::ucode_rom(pc_q);
		jump = 1'b0;
		unique case (uc.cond)
			svnh_pkg::COND_NEVER:     jump = 1'b0;
			svnh_pkg::COND_START:     jump = in_xfer;
			svnh_pkg::COND_NO_RINGS:  jump = (ring_count_q == '0);
			svnh_pkg::COND_RING_MORE: jump = (ring_q < ring_count_q);
			svnh_pkg::COND_DONE:      jump = ~res.busy & (~out_valid_q | ~out_stall);
			default:                  jump = 1'b0;
		endcase
		if (jump) begin
			pc_nxt = uc.target;
		end else if (uc.hold) begin
			pc_nxt = pc_q;
		end else begin
			pc_nxt = pc_q + 1'b1;
		end
		do_start = jump & (uc.cond == svnh_pkg::COND_START);
		do_ring  = jump & (uc.cond == svnh_pkg::COND_RING_MORE);
		do_done  = jump & (uc.cond == svnh_pkg::COND_DONE);
	end

	// Point request: offsets of the current ring and the weight shift.
	always_comb begin
		ring_ext  = {{(svnh_pkg::COORD_W - svnh_pkg::RING_W){1'b0}}, ring_q};
		req.valid = uc.issue;
		case (uc.dx)
			svnh_pkg::OFF_PLUS:  req.px = x_q + ring_ext;
			svnh_pkg::OFF_MINUS: req.px = x_q - ring_ext;
			default:             req.px = x_q;
		endcase
		case (uc.dy)
			svnh_pkg::OFF_PLUS:  req.py = y_q + ring_ext;
			svnh_pkg::OFF_MINUS: req.py = y_q - ring_ext;
			default:             req.py = y_q;
		endcase
		case (uc.wcls)
			svnh_pkg::WCLS_SIDE: req.shift = svnh_pkg::SH_SIDE0 - {ring_q, 1'b0};
			svnh_pkg::WCLS_DIAG: req.shift = svnh_pkg::SH_CENTER - {ring_q, 1'b0};
			default:             req.shift = svnh_pkg::SH_CENTER;
		endcase
	end

	svnh_hash_pipe u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.prime_a (prime_a_q),
		.prime_b (prime_b_q),
		.prime_c (prime_c_q),
		.req     (req),
		.res     (res)
	);

	// Sign-extended point value scaled to 46 fractional bits.
	assign contrib = {{(svnh_pkg::OUT_W - svnh_pkg::COORD_W){res.value[svnh_pkg::COORD_W-1]}},
			res.value} << res.shift;

	// Sequencer state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= svnh_pkg::PC_IDLE;
			ring_q      <= svnh_pkg::RING_RESET;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_nxt;
			if (do_start) begin
				ring_q <= svnh_pkg::RING_W'(1);
			end else if (do_ring) begin
				ring_q <= ring_q + 1'b1;
			end
			if (do_done) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Coordinates, accumulator and output register.
	always_ff @(posedge clk) begin
		if (do_start) begin
			x_q   <= coord_x;
			y_q   <= coord_y;
			acc_q <= '0;
		end else if (res.valid) begin
			acc_q <= acc_q + contrib;
		end
		if (do_done) begin
			out_q <= acc_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign noise_value = out_q;

	`SVNH_ASSERT(a_idle_pipe_empty, clk, arst_n, (pc_q == svnh_pkg::PC_IDLE) |-> !res.busy, "hash pipeline busy while idle")
	`SVNH_ASSERT(a_done_after_drain, clk, arst_n, do_done |-> (!res.valid && !u_hash.res.busy), "result loaded before drain")
	`SVNH_NEVER(a_ring_nonzero, clk, arst_n, (pc_q != svnh_pkg::PC_IDLE) && (ring_q == '0), "ring number zero during a walk")

endmodule

>>> rtl/core/svnh_hash_pipe.sv
// ----------------------------------------------------------------------------
// svnh_hash_pipe
// Five-stage pipelined lattice hash: one point in per cycle, Q2.30 value out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svnh_hash_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [svnh_pkg::PRIME_W-1:0]      prime_a,
	input  logic [svnh_pkg::PRIME_W-1:0]      prime_b,
	input  logic [svnh_pkg::PRIME_W-1:0]      prime_c,
	input  svnh_pkg::point_req_t              req,
	output svnh_pkg::point_res_t              res
);

	logic                             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [svnh_pkg::COORD_W-1:0]     px_s1, py_s1;
	logic [svnh_pkg::COORD_W-1:0]     n_s2, n_s3, n_s4;
	logic [svnh_pkg::COORD_W-1:0]     sq_s3, u_s4, v_s5;
	logic [svnh_pkg::SH_W-1:0]        sh_s1, sh_s2, sh_s3, sh_s4, sh_s5;
	logic [svnh_pkg::COORD_W-1:0]     n_mix, n_lin, sq_nxt, u_nxt, t_nxt;

	// Linear combination px + 57*py, then the shift-xor mix.
	assign n_lin = px_s1 + (py_s1 << 6) - (py_s1 << 3) + py_s1;
	assign n_mix = n_lin ^ (n_lin << 13);

	// Products keep their low 32 bits, as the hash wraps.
	assign sq_nxt = 32'(n_s2 * n_s2);
	assign u_nxt  = 32'(sq_s3 * {1'b0, prime_a}) + {1'b0, prime_b};
	assign t_nxt  = 32'(u_s4 * n_s4) + {1'b0, prime_c};

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage payloads; the last stage maps the 31-bit hash to 1 - m/2^30.
	always_ff @(posedge clk) begin
		px_s1 <= req.px;
		py_s1 <= req.py;
		sh_s1 <= req.shift;
		n_s2  <= n_mix;
		sh_s2 <= sh_s1;
		sq_s3 <= sq_nxt;
		n_s3  <= n_s2;
		sh_s3 <= sh_s2;
		u_s4  <= u_nxt;
		n_s4  <= n_s3;
		sh_s4 <= sh_s3;
		v_s5  <= svnh_pkg::VAL_ONE - {1'b0, t_nxt[30:0]};
		sh_s5 <= sh_s4;
	end

	assign res.valid = vld_s5;
	assign res.value = v_s5;
	assign res.shift = sh_s5;
	assign res.busy  = vld_s1 | vld_s2 | vld_s3 | vld_s4 | vld_s5;

	`SVNH_ASSERT(a_res_follows_req, clk, arst_n, res.valid |-> $past(req.valid, 5), "result without request")
	`SVNH_ASSERT(a_shift_range, clk, arst_n, res.valid |-> (res.shift <= svnh_pkg::SH_CENTER), "weight shift out of range")
	`SVNH_ASSERT(a_value_range, clk, arst_n, res.valid |-> ($signed(res.value) <= $signed(svnh_pkg::VAL_ONE)), "point value above one")

endmodule

>>> tb/svnh_noise_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svnh_noise_checker
// Watches the input, output and register channels of the smoothed value noise
// core. Each input transfer gets its exact expected noise value, and each
// output transfer is compared in order against those values.
// ----------------------------------------------------------------------------
module svnh_noise_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [svnh_pkg::COORD_W-1:0]         coord_x,
	input  logic [svnh_pkg::COORD_W-1:0]         coord_y,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [svnh_pkg::OUT_W-1:0]    noise_value,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [svnh_pkg::IDX_W-1:0]           cfg_index,
	input  logic [svnh_pkg::PRIME_W-1:0]         cfg_data,
	output int                                   error_count,
	output int                                   pending_count,
	output int                                   result_count
);
	import svnh_pkg::*;

	// One outstanding noise value with the point that produced it.
	typedef struct {
		logic [COORD_W-1:0]      x;
		logic [COORD_W-1:0]      y;
		logic signed [OUT_W-1:0] noise;
	} noise_expect_t;

	// Shadow copy of the configuration registers.
	logic [RING_W-1:0]  ring_sel;
	logic [PRIME_W-1:0] mult_a;
	logic [PRIME_W-1:0] add_b;
	logic [PRIME_W-1:0] add_c;

	noise_expect_t expected_noise[$];
	noise_expect_t head;

	// Q2.30 value of one lattice point: one minus the 31-bit hash over 2^30.
	function automatic logic signed [63:0] lattice_value(logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py);
		logic [31:0] n;
		logic [31:0] t;
		n = px + 32'd57 * py;
		n = n ^ (n << 13);
		t = n * (n * n * {1'b0, mult_a} + {1'b0, add_b}) + {1'b0, add_c};
		return 64'sd1073741824 - $signed({33'd0, t[30:0]});
	endfunction

	// Weighted sum over the center and the rings, with 46 fractional bits.
	function automatic logic signed [OUT_W-1:0] smoothed_noise(logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y);
		logic signed [63:0] acc;
		logic signed [63:0] sides;
		logic signed [63:0] diags;
		logic [COORD_W-1:0] d;
		int unsigned        rings;
		rings = (ring_sel > MAX_RINGS) ? MAX_RINGS : ring_sel;
		// The center weighs 1/4, which is a shift of 14 from Q2.30.
		acc = lattice_value(x, y) <<< 14;
		for (int i = 1; i <= rings; i++) begin
			d = i;
			sides = lattice_value(x + d, y) + lattice_value(x - d, y)
				+ lattice_value(x, y + d) + lattice_value(x, y - d);
			diags = lattice_value(x - d, y - d) + lattice_value(x + d, y - d)
				+ lattice_value(x - d, y + d) + lattice_value(x + d, y + d);
			acc += sides <<< (15 - 2 * i);
			acc += diags <<< (14 - 2 * i);
		end
		return acc[OUT_W-1:0];
	endfunction

	// Print one line per mismatch, up to a cap, and count every one.
	task automatic report_mismatch(string what);
		if (error_count < 40) begin
			$display("[%0t] ERROR: %s", $time, what);
		end
		error_count++;
	endtask

	// All channels are sampled at the rising edge, where transfers happen.
	always @(posedge clk) begin
		if (!arst_n) begin
			ring_sel = RING_RESET;
			mult_a = PA_RESET;
			add_b = PB_RESET;
			add_c = PC_RESET;
			expected_noise.delete();
			error_count = 0;
			result_count = 0;
		end else begin
			// Register writes update the shadow copy.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RING_COUNT: ring_sel = cfg_data[RING_W-1:0];
					REG_PRIME_A:    mult_a = cfg_data;
					REG_PRIME_B:    add_b = cfg_data;
					REG_PRIME_C:    add_c = cfg_data;
					default: ;
				endcase
			end

			// Every input transfer yields exactly one expected value.
			if (in_valid && !in_stall) begin
				head.x = coord_x;
				head.y = coord_y;
				head.noise = smoothed_noise(coord_x, coord_y);
				expected_noise.push_back(head);
			end

			// Each output transfer is matched against the oldest expectation.
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_noise.size() == 0) begin
					report_mismatch($sformatf("noise_value %h with no point outstanding",
						noise_value));
				end else begin
					head = expected_noise.pop_front();
					if (noise_value !== head.noise) begin
						report_mismatch($sformatf(
							"point (%0d, %0d): noise_value %h, expected %h",
							$signed(head.x), $signed(head.y), noise_value, head.noise));
					end
				end
			end
		end
		pending_count = expected_noise.size();
	end

endmodule

>>> tb/tb_smoothed_value_noise_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothed_value_noise_hash_core
// Drives coordinate pairs and register settings into the smoothed value noise
// core, with random idle bursts on both sides and one long output hold-off.
// A checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_smoothed_value_noise_hash_core;
	import svnh_pkg::*;

	localparam int unsigned PHASES        = 12;
	localparam int unsigned PHASE_ITEMS   = 112;
	localparam int unsigned HOLD_CYCLES   = 160;
	localparam int unsigned SETTLE_CYCLES = 8 + 8 * MAX_RINGS + 16;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [COORD_W-1:0]  coord_x;
	logic signed [COORD_W-1:0]  coord_y;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [OUT_W-1:0]    noise_value;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [IDX_W-1:0]           cfg_index;
	logic [PRIME_W-1:0]         cfg_data;

	int          error_count;
	int          pending_count;
	int          result_count;
	int unsigned hold_off_len;
	bit          tx_bursts;
	bit          rx_bursts;
	int unsigned points_sent;
	int unsigned settings_applied;

	smoothed_value_noise_hash_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.noise_value (noise_value),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	svnh_noise_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.noise_value   (noise_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.error_count   (error_count),
		.pending_count (pending_count),
		.result_count  (result_count)
	);

	// 100 MHz clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Output side: random stall bursts, or one long counted hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_len != 0) begin
				out_stall = 1'b1;
				repeat (hold_off_len) @(negedge clk);
				hold_off_len = 0;
				out_stall = 1'b0;
			end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// Random coordinate: full range, near zero, or near either end of the range.
	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 5))
			1:       return 32'($urandom_range(0, 40)) - 32'd20;
			2:       return 32'h7fff_ffff - 32'($urandom_range(0, 10));
			3:       return 32'h8000_0000 + 32'($urandom_range(0, 10));
			default: return $urandom;
		endcase
	endfunction

	// Random prime register value: zero, all ones, the reset value, or anything.
	function automatic logic [PRIME_W-1:0] pick_prime(logic [PRIME_W-1:0] reset_val);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return reset_val;
			default: return PRIME_W'($urandom);
		endcase
	endfunction

	// One coordinate transfer, preceded by an occasional idle burst.
	task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		if (tx_bursts && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		coord_x = x;
		coord_y = y;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		points_sent++;
	endtask

	// One register write transfer.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [PRIME_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait until the core is idle, then load a full register setting.
	task automatic apply_setting(logic [RING_W-1:0] rings, logic [PRIME_W-1:0] a,
			logic [PRIME_W-1:0] b, logic [PRIME_W-1:0] c);
		in_valid = 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		write_reg(REG_RING_COUNT, PRIME_W'(rings));
		write_reg(REG_PRIME_A, a);
		write_reg(REG_PRIME_B, b);
		write_reg(REG_PRIME_C, c);
		settings_applied++;
	endtask

	// Stimulus and verdict.
	initial begin
		logic [RING_W-1:0] rings;
		bit                last_phase;
		in_valid = 1'b0;
		coord_x = '0;
		coord_y = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RING_COUNT;
		cfg_data = '0;
		hold_off_len = 0;
		tx_bursts = 1'b1;
		rx_bursts = 1'b1;
		points_sent = 0;
		settings_applied = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset setting, extreme points; ring offsets wrap around the range ends.
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'h7fff_ffff, 32'h8000_0000);
		send_point(32'h8000_0000, 32'h7fff_ffff);
		send_point(32'hffff_ffff, 32'hffff_ffff);
		send_point(32'h0000_0001, 32'hffff_ffff);
		send_point(32'h5555_5555, 32'haaaa_aaaa);

		// No rings: the center value alone at a quarter weight.
		apply_setting(3'd0, PA_RESET, PB_RESET, PC_RESET);
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h8000_0000, 32'h7fff_ffff);
		send_point(32'hffff_ffff, 32'h0000_0001);
		send_point(32'haaaa_aaaa, 32'h5555_5555);

		// Largest ring count, with coordinates close enough to the ends to wrap.
		apply_setting(3'(MAX_RINGS), PA_RESET, PB_RESET, PC_RESET);
		send_point(32'h7fff_fffc, 32'h8000_0003);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'hffff_fffd, 32'h0000_0002);
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h1234_5678, 32'hedcb_a987);

		// Extreme hash constants: all zero, then all ones.
		apply_setting(3'd1, '0, '0, '0);
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'hdead_beef, 32'h0bad_f00d);
		apply_setting(3'(MAX_RINGS), '1, '1, '1);
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h8000_0000, 32'h7fff_ffff);
		send_point($urandom, $urandom);

		// Random phases, each with its own setting. The last one runs without idling.
		for (int p = 0; p < PHASES; p++) begin
			last_phase = (p == PHASES - 1);
			if (p == 0) begin
				rings = 3'd0;
			end else if (p == 1) begin
				rings = 3'(MAX_RINGS);
			end else begin
				rings = 3'($urandom_range(0, MAX_RINGS));
			end
			if (p < 2 || last_phase) begin
				apply_setting(rings, PA_RESET, PB_RESET, PC_RESET);
			end else begin
				apply_setting(rings, pick_prime(PA_RESET), pick_prime(PB_RESET),
					pick_prime(PC_RESET));
			end
			tx_bursts = !last_phase && (p % 4 != 2);
			rx_bursts = !last_phase && (p % 4 != 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Hold the output off long enough for the core to back up its input.
				if (p == 3 && k == 20) begin
					hold_off_len = HOLD_CYCLES;
				end
				send_point(pick_coord(), pick_coord());
			end
		end

		// Drain everything outstanding, then allow the core to settle.
		in_valid = 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Summary: %0d coordinate pairs sent and %0d noise values checked.",
			points_sent, result_count);
		$display("Summary: %0d register settings, ring counts from 0 to %0d.",
			settings_applied, MAX_RINGS);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
